// ===== rtl/edfts_pkg.sv =====
// edfts_pkg: shared constants, request codes and inter-module structs
// for the earliest-deadline-first tick scheduler; no dependencies
`timescale 1ns / 1ps

package edfts_pkg;

  localparam int SLOTS      = 16;
  localparam int TIME_BITS  = 16;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W       = 8;
  localparam int DATA_W     = 16;
  localparam int OUT_SLOT_W = 4;
  localparam int CMP_W      = 32;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 wr_en;
    logic [SLOT_W-1:0]    wr_slot;
    logic [ID_W-1:0]      wr_id;
    logic [DATA_W-1:0]    wr_arr;
    logic [DATA_W-1:0]    wr_work;
    logic [DATA_W-1:0]    wr_dl;
    logic                 dec_en;
    logic [SLOT_W-1:0]    dec_slot;
    logic [TIME_BITS-1:0] now;
  } cmd_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [DATA_W-1:0] dl;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   id;
    logic              rem_one;
    logic              any_nz;
    logic              multi;
  } tok_t;

endpackage

// ===== rtl/edfts_cell.sv =====
// edfts_cell: one task-table slot plus one stage of the deadline scan chain
// depends on edfts_pkg
`timescale 1ns / 1ps

module edfts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [edfts_pkg::SLOT_W-1:0]  cell_idx,
  input  edfts_pkg::cmd_t               cmd,
  input  edfts_pkg::tok_t               tok_in,
  output edfts_pkg::tok_t               tok_out
);
  import edfts_pkg::*;

  logic [ID_W-1:0]   id_r;
  logic [DATA_W-1:0] arr_r;
  logic [DATA_W-1:0] dl_r;
  logic [DATA_W-1:0] rem_r;
  tok_t              tok_r;
  tok_t              tok_nxt;

  logic wr_hit;
  logic dec_hit;
  logic own_nz;
  logic own_rdy;
  logic take;

  assign wr_hit  = cmd.wr_en && (cmd.wr_slot == cell_idx);
  assign dec_hit = cmd.dec_en && (cmd.dec_slot == cell_idx);
  assign own_nz  = (rem_r != '0);
  assign own_rdy = own_nz && (CMP_W'(arr_r) <= CMP_W'(cmd.now));
  // strict compare: an earlier slot keeps a tie
  assign take    = own_rdy && (!tok_in.found || (dl_r < tok_in.dl));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      id_r  <= cmd.wr_id;
      arr_r <= cmd.wr_arr;
      dl_r  <= cmd.wr_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (wr_hit) begin
      rem_r <= cmd.wr_work;
    end else if (dec_hit) begin
      rem_r <= rem_r - DATA_W'(1);
    end
  end

  always_comb begin
    tok_nxt        = tok_in;
    tok_nxt.any_nz = tok_in.any_nz | own_nz;
    tok_nxt.multi  = tok_in.multi | (tok_in.any_nz & own_nz);
    if (take) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.dl      = dl_r;
      tok_nxt.slot    = cell_idx;
      tok_nxt.id      = id_r;
      tok_nxt.rem_one = (rem_r == DATA_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/edfts_ctrl.sv =====
// edfts_ctrl: request handshake, scan sequencing, tick counter and result register
// depends on edfts_pkg
`timescale 1ns / 1ps

module edfts_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [3:0]                  in_slot,
  input  logic [7:0]                  in_task_id,
  input  logic [15:0]                 in_arrival,
  input  logic [15:0]                 in_work,
  input  logic [15:0]                 in_deadline,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_ran_valid,
  output logic [3:0]                  out_ran_slot,
  output logic [7:0]                  out_ran_id,
  output logic                        out_finished,
  output logic                        out_all_done,
  output logic [15:0]                 out_time_now,
  output edfts_pkg::cmd_t             cmd,
  output edfts_pkg::tok_t             tok_head,
  input  edfts_pkg::tok_t             tok_tail
);
  import edfts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INJ  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 is_tick_r;
  logic [TIME_BITS-1:0] tick_r;

  logic                  hold_valid_r, hold_fin_r, hold_done_r;
  logic [OUT_SLOT_W-1:0] hold_slot_r;
  logic [ID_W-1:0]       hold_id_r;
  logic [15:0]           hold_time_r;

  logic                  res_valid, res_fin, res_done;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic [ID_W-1:0]       res_id;

  logic in_acc, out_free, scan_end, load_now, load_hold;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign scan_end = (state_r == S_SCAN) && tok_tail.vld;
  assign load_now  = scan_end && out_free;
  assign load_hold = (state_r == S_FIN) && out_free;

  // result of the finished scan
  always_comb begin
    res_valid = 1'b0;
    res_slot  = '0;
    res_id    = '0;
    res_fin   = 1'b0;
    res_done  = !tok_tail.any_nz;
    if (is_tick_r && tok_tail.found) begin
      res_valid = 1'b1;
      res_slot  = OUT_SLOT_W'(tok_tail.slot);
      res_id    = tok_tail.id;
      res_fin   = tok_tail.rem_one;
      res_done  = tok_tail.rem_one && !tok_tail.multi;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.wr_en    = in_acc && (in_req_type == REQ_LOAD) &&
                   ((9)'(in_slot) < (9)'(SLOTS));
    cmd.wr_slot  = SLOT_W'(in_slot);
    cmd.wr_id    = in_task_id;
    cmd.wr_arr   = in_arrival;
    cmd.wr_work  = in_work;
    cmd.wr_dl    = in_deadline;
    cmd.dec_en   = scan_end && is_tick_r && tok_tail.found;
    cmd.dec_slot = tok_tail.slot;
    cmd.now      = tick_r;
  end

  always_comb begin
    tok_head     = '0;
    tok_head.vld = (state_r == S_INJ);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_INJ;
      S_INJ:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) state_nxt = out_free ? S_IDLE : S_FIN;
      end
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tick_r    <= '0;
      out_valid <= 1'b0;
      is_tick_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        is_tick_r <= (in_req_type == REQ_TICK);
      end
      if (scan_end && is_tick_r && (tick_r != TIME_MAX)) begin
        tick_r <= tick_r + TIME_BITS'(1);
      end
      if (load_now || load_hold) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (scan_end && !out_free) begin
      hold_valid_r <= res_valid;
      hold_slot_r  <= res_slot;
      hold_id_r    <= res_id;
      hold_fin_r   <= res_fin;
      hold_done_r  <= res_done;
      hold_time_r  <= 16'(tick_r);
    end
    if (load_now) begin
      out_ran_valid <= res_valid;
      out_ran_slot  <= res_slot;
      out_ran_id    <= res_id;
      out_finished  <= res_fin;
      out_all_done  <= res_done;
      out_time_now  <= 16'(tick_r);
    end else if (load_hold) begin
      out_ran_valid <= hold_valid_r;
      out_ran_slot  <= hold_slot_r;
      out_ran_id    <= hold_id_r;
      out_finished  <= hold_fin_r;
      out_all_done  <= hold_done_r;
      out_time_now  <= hold_time_r;
    end
  end

endmodule

// ===== rtl/edf_tick_scheduler.sv =====
// edf_tick_scheduler: earliest-deadline-first task scheduler, one work unit per tick
// an accepted request injects a scan token that walks the row of slot cells
//   one cell a cycle; the result it carries is then registered for output
// a new request is taken only once the previous result has gone to the outputs
// reset: synchronous active-low; clears remaining work of every slot, the tick
//   counter and all handshake state; ids, arrivals and deadlines stay as they were
`timescale 1ns / 1ps

module edf_tick_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [3:0]  in_slot,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_arrival,
  input  logic [15:0] in_work,
  input  logic [15:0] in_deadline,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ran_valid,
  output logic [3:0]  out_ran_slot,
  output logic [7:0]  out_ran_id,
  output logic        out_finished,
  output logic        out_all_done,
  output logic [15:0] out_time_now
);
  import edfts_pkg::*;

  // broadcast command: load write at request acceptance, decrement of the
  // winner and the current tick once the scan is over
  cmd_t cmd;

  // scan chain: tok[0] is injected by the controller, tok[SLOTS] comes back
  // carrying the winner, whether it ends now and if none, one or more slots hold work
  tok_t tok [SLOTS+1];

  edfts_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_slot       (in_slot),
    .in_task_id    (in_task_id),
    .in_arrival    (in_arrival),
    .in_work       (in_work),
    .in_deadline   (in_deadline),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ran_valid (out_ran_valid),
    .out_ran_slot  (out_ran_slot),
    .out_ran_id    (out_ran_id),
    .out_finished  (out_finished),
    .out_all_done  (out_all_done),
    .out_time_now  (out_time_now),
    .cmd           (cmd),
    .tok_head      (tok[0]),
    .tok_tail      (tok[SLOTS])
  );

  // one cell per slot; a lower slot sees the token first so it wins ties
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    edfts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .cmd      (cmd),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
  end

endmodule
